// ===== sv/olad_pkg.sv =====
// package: shared constants, codes and types of the ordered list store
`timescale 1ns / 1ps
`default_nettype none
package olad_pkg;

   localparam int DEPTH   = 32;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   // action codes
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_DELETE = 2'd1;
   localparam logic [1:0] ACT_READ   = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   // cell operations
   localparam logic [1:0] OP_HOLD   = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;
   localparam logic [1:0] OP_ROTATE = 2'd3;

   typedef logic signed [31:0] value_type;

   // broadcast to every cell
   typedef struct packed {
      logic [1:0] op;
      value_type  key;
   } cell_ctl_type;

   // what a cell shows its neighbors
   typedef struct packed {
      logic      valid;
      value_type value;
   } cell_link_type;

endpackage
`default_nettype wire

// ===== sv/olad_if.sv =====
// interfaces: request and response channels of the ordered list store
`timescale 1ns / 1ps
`default_nettype none
interface olad_req_if;
   logic                valid;
   logic                ready;
   logic [1:0]          action;
   olad_pkg::value_type item_value;

   modport source (output valid, output action, output item_value, input ready);
   modport sink   (input valid, input action, input item_value, output ready);
endinterface

interface olad_rsp_if;
   logic                valid;
   logic                ready;
   olad_pkg::value_type out_value;
   logic [1:0]          status;
   logic                last_item;

   modport source (output valid, output out_value, output status, output last_item,
                   input ready);
   modport sink   (input valid, input out_value, input status, input last_item,
                   output ready);
endinterface
`default_nettype wire

// ===== sv/olad_cell.sv =====
// list cell: one slot of the ordered list, shifts and rotates with its neighbors
`timescale 1ns / 1ps
`default_nettype none
module olad_cell (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire olad_pkg::cell_ctl_type  ctl,
   input  wire logic                    left_valid,
   input  wire logic                    left_hit,
   input  wire olad_pkg::cell_link_type right,
   input  wire olad_pkg::value_type     head_value,
   output      olad_pkg::cell_link_type self,
   output      logic                    hit_out
);

   logic                valid_ff, valid_in;
   olad_pkg::value_type value_ff, value_in;

   // first match from the head: this cell or any cell before it
   assign hit_out = left_hit | (valid_ff & (value_ff == ctl.key));

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      unique case (ctl.op)
         olad_pkg::OP_INSERT: begin
            if (!valid_ff && left_valid) begin
               valid_in = 1'b1;
               value_in = ctl.key;
            end
         end
         olad_pkg::OP_DELETE: begin
            if (hit_out) begin
               valid_in = right.valid;
               value_in = right.value;
            end
         end
         olad_pkg::OP_ROTATE: begin
            if (valid_ff) begin
               value_in = right.valid ? right.value : head_value;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   assign self.valid = valid_ff;
   assign self.value = value_ff;

endmodule
`default_nettype wire

// ===== sv/ordered_list_append_delete.sv =====
// top level: ordered list store built as a chain of list cells
//
// usage
//   req channel: one beat carries action and item_value; rsp channel: each beat
//   carries out_value, status and last_item. valid/ready on both, a beat moves
//   when both are high.
//   insert and delete finish in the accept cycle; their single response beat
//   shows on rsp in the next cycle, so one such request can be taken every cycle
//   while rsp keeps draining.
//   read out gives one beat per list item: the chain rotates one slot
//   per response beat and the head cell feeds rsp, so the list is back in order
//   once the tail beat has left. no request is taken during read out.
//   an empty read out, and every insert or delete, gives one beat with
//   last_item set. the unused action code is accepted and gives no beat.
//   reset empties the list at once (slot occupancy bits clear) and drops any
//   pending response; values in the slots are left as they are.
//   when rsp stalls the response register holds its beat and req is held off
//   until the beat is taken; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module ordered_list_append_delete (
   input  wire logic  clock,
   input  wire logic  reset,
   olad_req_if.sink   req,
   olad_rsp_if.source rsp
);

   localparam logic STATE_IDLE = 1'b0;
   localparam logic STATE_READ = 1'b1;

   logic                          state_ff, state_in;
   logic [olad_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [olad_pkg::COUNT_W-1:0]  remain_ff, remain_in;

   // response register
   logic                          rsp_valid_ff, rsp_valid_in;
   olad_pkg::value_type           out_value_ff, out_value_in;
   logic [1:0]                    status_ff, status_in;
   logic                          last_ff, last_in;

   olad_pkg::cell_ctl_type        ctl;
   olad_pkg::cell_link_type       link [olad_pkg::DEPTH];
   logic [olad_pkg::DEPTH-1:0]    hit;
   logic [olad_pkg::DEPTH-1:0]    occupied;

   logic                          out_free;
   logic                          accept;
   logic                          is_full;
   logic                          is_empty;
   logic                          found;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == STATE_IDLE) && out_free;
   assign accept = req.valid && req.ready;
   assign is_full = (count_ff == olad_pkg::COUNT_W'(olad_pkg::DEPTH));
   assign is_empty = (count_ff == '0);
   assign found = hit[olad_pkg::DEPTH-1];

   // cell operation broadcast along the chain
   always_comb begin
      ctl.key = req.item_value;
      ctl.op  = olad_pkg::OP_HOLD;
      if (state_ff == STATE_READ) begin
         if (out_free) begin
            ctl.op = olad_pkg::OP_ROTATE;
         end
      end else if (accept) begin
         if (req.action == olad_pkg::ACT_INSERT) begin
            ctl.op = olad_pkg::OP_INSERT;
         end else if (req.action == olad_pkg::ACT_DELETE) begin
            ctl.op = olad_pkg::OP_DELETE;
         end
      end
   end

   // the chain: slot 0 is the head
   for (genvar i = 0; i < olad_pkg::DEPTH; i++) begin : g_cell
      olad_pkg::cell_link_type right;
      logic                    left_valid;
      logic                    left_hit;

      if (i == 0) begin : g_head
         assign left_valid = 1'b1;
         assign left_hit   = 1'b0;
      end else begin : g_body
         assign left_valid = link[i-1].valid;
         assign left_hit   = hit[i-1];
      end

      if (i == olad_pkg::DEPTH - 1) begin : g_tail
         assign right.valid = 1'b0;
         assign right.value = link[i].value;
      end else begin : g_inner
         assign right = link[i+1];
      end

      olad_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .left_valid (left_valid),
         .left_hit   (left_hit),
         .right      (right),
         .head_value (link[0].value),
         .self       (link[i]),
         .hit_out    (hit[i])
      );

      assign occupied[i] = link[i].valid;
   end

   // control, count and response register
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      out_value_in = out_value_ff;
      status_in    = status_ff;
      last_in      = last_ff;

      if (state_ff == STATE_READ) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            out_value_in = link[0].value;
            status_in    = olad_pkg::ST_OK;
            last_in      = (remain_ff == olad_pkg::COUNT_W'(1));
            remain_in    = remain_ff - olad_pkg::COUNT_W'(1);
            if (remain_ff == olad_pkg::COUNT_W'(1)) begin
               state_in = STATE_IDLE;
            end
         end
      end else if (accept) begin
         out_value_in = req.item_value;
         last_in      = 1'b1;
         unique case (req.action)
            olad_pkg::ACT_INSERT: begin
               rsp_valid_in = 1'b1;
               if (is_full) begin
                  status_in = olad_pkg::ST_FULL;
               end else begin
                  status_in = olad_pkg::ST_OK;
                  count_in  = count_ff + olad_pkg::COUNT_W'(1);
               end
            end
            olad_pkg::ACT_DELETE: begin
               rsp_valid_in = 1'b1;
               if (is_empty) begin
                  status_in = olad_pkg::ST_EMPTY;
               end else if (!found) begin
                  status_in = olad_pkg::ST_NOTFOUND;
               end else begin
                  status_in = olad_pkg::ST_OK;
                  count_in  = count_ff - olad_pkg::COUNT_W'(1);
               end
            end
            olad_pkg::ACT_READ: begin
               if (is_empty) begin
                  rsp_valid_in = 1'b1;
                  out_value_in = '0;
                  status_in    = olad_pkg::ST_EMPTY;
               end else begin
                  state_in  = STATE_READ;
                  remain_in = count_ff;
               end
            end
            default: begin
               // unused code: taken and dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      out_value_ff <= out_value_in;
      status_ff    <= status_in;
      last_ff      <= last_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_value = out_value_ff;
   assign rsp.status    = status_ff;
   assign rsp.last_item = last_ff;

   // count tracks the occupancy bits of the chain
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      count_ff == olad_pkg::COUNT_W'($countones(occupied)))
      else $error("list count disagrees with cell occupancy");

   // occupied slots stay packed against the head
   a_packed: assert property (@(posedge clock) disable iff (reset)
      (occupied & (occupied + 1'b1)) == '0)
      else $error("gap in the cell chain");

   // no request is taken while the list is being read out
   a_no_accept_in_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == STATE_READ) |-> !req.ready)
      else $error("request ready during read out");

   // an insert into a list with room grows it by one
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && req.action == olad_pkg::ACT_INSERT && !is_full)
         |=> count_ff == $past(count_ff) + olad_pkg::COUNT_W'(1))
      else $error("insert did not grow the list");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// testbench: self-checking bench for the ordered list store with random handshake pressure
`timescale 1ns / 1ps
module testbench;

   localparam int WATCHDOG_LIMIT = 5000;   // cycles with no beat on either channel
   localparam int SHOWN_ERRORS   = 10;
   localparam int TAIL_CYCLES    = 40;     // room for stray beats after the last one
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam olad_pkg::value_type VAL_MIN = 32'sh8000_0000;
   localparam olad_pkg::value_type VAL_MAX = 32'sh7fff_ffff;

   // one request beat
   typedef struct packed {
      logic [1:0]          action;
      olad_pkg::value_type item_value;
   } list_cmd_type;

   // one response beat
   typedef struct packed {
      olad_pkg::value_type out_value;
      logic [1:0]          status;
      logic                last_item;
   } list_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   olad_req_if req_if ();
   olad_rsp_if rsp_if ();

   ordered_list_append_delete dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   always #5 clock = ~clock;

   // stimulus waiting to be driven, expected beats waiting to arrive
   list_cmd_type cmd_queue[$];
   list_rsp_type due_rsp_beats[$];

   // image of the list contents, head at index 0
   olad_pkg::value_type list_image[$];

   // values inserted recently, used to aim deletes at real entries
   olad_pkg::value_type recent_values[$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   int error_count   = 0;
   int cmds_taken    = 0;
   int beats_checked = 0;
   int peak_len      = 0;
   int full_seen     = 0;
   int notfound_seen = 0;
   int empty_seen    = 0;
   int readouts_seen = 0;
   int quiet_cycles  = 0;

   // list behavior: apply one accepted command and queue the beats it causes
   task automatic update_list_image(input list_cmd_type cmd);
      list_rsp_type beat;
      int           hit;
      hit = -1;
      case (cmd.action)
         olad_pkg::ACT_INSERT: begin
            beat = '{cmd.item_value, olad_pkg::ST_OK, 1'b1};
            if (list_image.size() >= olad_pkg::DEPTH) begin
               // no room: value dropped
               beat.status = olad_pkg::ST_FULL;
               full_seen++;
            end else begin
               list_image.push_back(cmd.item_value);
            end
            due_rsp_beats.push_back(beat);
         end
         olad_pkg::ACT_DELETE: begin
            beat = '{cmd.item_value, olad_pkg::ST_OK, 1'b1};
            if (list_image.size() == 0) begin
               beat.status = olad_pkg::ST_EMPTY;
               empty_seen++;
            end else begin
               // first match from the head, raw bit compare
               for (int i = 0; i < list_image.size(); i++) begin
                  if (hit < 0 && list_image[i] == cmd.item_value) begin
                     hit = i;
                  end
               end
               if (hit < 0) begin
                  beat.status = olad_pkg::ST_NOTFOUND;
                  notfound_seen++;
               end else begin
                  list_image.delete(hit);
               end
            end
            due_rsp_beats.push_back(beat);
         end
         olad_pkg::ACT_READ: begin
            readouts_seen++;
            if (list_image.size() == 0) begin
               due_rsp_beats.push_back('{32'sd0, olad_pkg::ST_EMPTY, 1'b1});
               empty_seen++;
            end else begin
               for (int i = 0; i < list_image.size(); i++) begin
                  due_rsp_beats.push_back('{list_image[i], olad_pkg::ST_OK,
                                            logic'(i == list_image.size() - 1)});
               end
            end
         end
         default: ;  // unused code: no beat, list untouched
      endcase
      if (list_image.size() > peak_len) begin
         peak_len = list_image.size();
      end
   endtask

   // compare one response beat against the oldest expectation
   task automatic check_rsp_beat(input list_rsp_type got);
      list_rsp_type want;
      if (due_rsp_beats.size() == 0) begin
         error_count++;
         if (error_count <= SHOWN_ERRORS) begin
            $display("ERROR %0t: unexpected beat value=%0d status=%0d last=%0b",
                     $realtime, got.out_value, got.status, got.last_item);
         end
      end else begin
         want = due_rsp_beats.pop_front();
         beats_checked++;
         if (got.out_value !== want.out_value || got.status !== want.status ||
             got.last_item !== want.last_item) begin
            error_count++;
            if (error_count <= SHOWN_ERRORS) begin
               $display("ERROR %0t: beat %0d expected value=%0d status=%0d last=%0b",
                        $realtime, beats_checked, want.out_value, want.status,
                        want.last_item);
               $display("             got      value=%0d status=%0d last=%0b",
                        got.out_value, got.status, got.last_item);
            end
         end
      end
   endtask

   // driver: hold a beat until taken, then maybe offer the next one
   always @(posedge clock) begin
      list_cmd_type next_cmd;
      if (reset) begin
         req_if.valid      <= 1'b0;
         req_if.action     <= olad_pkg::ACT_INSERT;
         req_if.item_value <= '0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            update_list_image('{req_if.action, req_if.item_value});
            cmds_taken++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               next_cmd = cmd_queue.pop_front();
               req_if.valid      <= 1'b1;
               req_if.action     <= next_cmd.action;
               req_if.item_value <= next_cmd.item_value;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each response beat, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            check_rsp_beat('{rsp_if.out_value, rsp_if.status, rsp_if.last_item});
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog: too long without any beat moving means the block hung
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TIMEOUT: no beat for %0d cycles, %0d beats still due",
                  WATCHDOG_LIMIT, due_rsp_beats.size());
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_cmd(input logic [1:0] action, input olad_pkg::value_type value);
      cmd_queue.push_back('{action, value});
      if (action == olad_pkg::ACT_INSERT) begin
         recent_values.push_back(value);
         if (recent_values.size() > 16) begin
            void'(recent_values.pop_front());
         end
      end
   endtask

   // mix of small repeating values (for duplicates) and full-range ones
   function automatic olad_pkg::value_type pick_value();
      olad_pkg::value_type pool[8];
      pool = '{-2, -1, 0, 1, 2, 3, VAL_MIN, VAL_MAX};
      if ($urandom_range(99) < 40) begin
         return pool[$urandom_range(7)];
      end
      return olad_pkg::value_type'($urandom);
   endfunction

   // random commands; optional fill burst drives the list past full
   task automatic random_phase(input int count, input bit with_fill);
      int roll;
      int issued;
      issued = 0;
      if (with_fill) begin
         for (int i = 0; i < olad_pkg::DEPTH + 2; i++) begin
            push_cmd(olad_pkg::ACT_INSERT, pick_value());
         end
         push_cmd(olad_pkg::ACT_READ, olad_pkg::value_type'($urandom));
      end
      while (issued < count) begin
         roll = $urandom_range(99);
         if (roll < 45) begin
            push_cmd(olad_pkg::ACT_INSERT, pick_value());
            issued++;
         end else if (roll < 80) begin
            // mostly aim at something that was inserted
            if (recent_values.size() > 0 && $urandom_range(99) < 70) begin
               push_cmd(olad_pkg::ACT_DELETE,
                        recent_values[$urandom_range(recent_values.size() - 1)]);
            end else begin
               push_cmd(olad_pkg::ACT_DELETE, pick_value());
            end
            issued++;
         end else if (roll < 95) begin
            push_cmd(olad_pkg::ACT_READ, olad_pkg::value_type'($urandom));
            issued++;
         end else begin
            // ignored by the block, not counted
            push_cmd(ACT_UNUSED, olad_pkg::value_type'($urandom));
         end
      end
   endtask

   task automatic wait_cmds_sent();
      while (cmd_queue.size() > 0 || req_if.valid) begin
         @(posedge clock);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty cases, extremes, duplicates, head/middle/tail deletes
      push_cmd(olad_pkg::ACT_READ,   32'sd0);
      push_cmd(olad_pkg::ACT_DELETE, 32'sd5);
      push_cmd(olad_pkg::ACT_INSERT, VAL_MIN);
      push_cmd(olad_pkg::ACT_INSERT, VAL_MAX);
      push_cmd(olad_pkg::ACT_INSERT, 32'sd0);
      push_cmd(olad_pkg::ACT_INSERT, -32'sd1);
      push_cmd(olad_pkg::ACT_INSERT, VAL_MAX);
      push_cmd(olad_pkg::ACT_INSERT, 32'sd1);
      push_cmd(olad_pkg::ACT_READ,   32'sh5a5a_a5a5);
      push_cmd(olad_pkg::ACT_DELETE, 32'sd7);
      push_cmd(olad_pkg::ACT_DELETE, VAL_MAX);
      push_cmd(olad_pkg::ACT_READ,   -32'sd1);
      push_cmd(ACT_UNUSED,           32'shaaaa_5555);
      push_cmd(olad_pkg::ACT_DELETE, VAL_MIN);
      push_cmd(olad_pkg::ACT_DELETE, 32'sd1);
      push_cmd(olad_pkg::ACT_DELETE, VAL_MAX);
      push_cmd(olad_pkg::ACT_READ,   32'sd0);
      push_cmd(olad_pkg::ACT_DELETE, 32'sd0);
      push_cmd(olad_pkg::ACT_DELETE, -32'sd1);
      push_cmd(olad_pkg::ACT_READ,   VAL_MAX);
      push_cmd(olad_pkg::ACT_INSERT, 32'sh5555_aaaa);
      push_cmd(olad_pkg::ACT_DELETE, 32'sh5555_aaaa);

      // no idling on either side
      random_phase(25, 1'b1);
      wait_cmds_sent();

      // sender mostly idle
      send_idle_pct  = 76;
      recv_stall_pct = 0;
      random_phase(25, 1'b0);
      wait_cmds_sent();

      // receiver mostly stalled
      send_idle_pct  = 0;
      recv_stall_pct = 76;
      random_phase(25, 1'b0);
      wait_cmds_sent();

      // light idling on both sides, with another fill to full
      send_idle_pct  = 10;
      recv_stall_pct = 10;
      random_phase(25, 1'b1);
      wait_cmds_sent();

      // drain with the receiver always ready
      recv_stall_pct = 0;
      while (due_rsp_beats.size() > 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      if (due_rsp_beats.size() > 0) begin
         error_count++;
         $display("ERROR: %0d expected beats never arrived", due_rsp_beats.size());
      end

      $display("covered %0d commands, %0d response beats, %0d read outs, peak length %0d",
               cmds_taken, beats_checked, readouts_seen, peak_len);
      $display("status cases: %0d full, %0d not found, %0d empty; %0d mismatches",
               full_seen, notfound_seen, empty_seen, error_count);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
